>>> rtl/dsj_pkg.sv
`default_nettype none

package dsj_pkg;

    // sizes
    localparam int MAX_ELEMENTS = 1024;
    localparam int LBL_W        = $clog2(MAX_ELEMENTS);
    localparam int IDX_W        = LBL_W + 1;
    localparam int ELEM_W       = 11;
    localparam int CNT_W        = 11;
    localparam int SUM_W        = 20;

    // opcodes
    localparam logic [1:0] OP_JOIN  = 2'd0;
    localparam logic [1:0] OP_MOVE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // per-label statistics word
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum;
    } stat_t;

    // label memory port request
    typedef struct packed {
        logic             we;
        logic [LBL_W-1:0] waddr;
        logic [LBL_W-1:0] wdata;
        logic             re;
        logic [LBL_W-1:0] raddr;
    } lbl_req_t;

    // statistics memory port request
    typedef struct packed {
        logic             we;
        logic [LBL_W-1:0] waddr;
        stat_t            wdata;
        logic             re;
        logic [LBL_W-1:0] raddr;
    } st_req_t;

    // query result toward the output register
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] size;
        logic [SUM_W-1:0] sum;
    } res_t;

    // element in 1..element_count and inside the store
    function automatic logic elem_ok(input logic [ELEM_W-1:0] e,
                                     input logic [ELEM_W-1:0] cnt);
        return (e != '0) && (e <= cnt) && (e <= ELEM_W'(MAX_ELEMENTS));
    endfunction

    // element number to label store address
    function automatic logic [LBL_W-1:0] elem_addr(input logic [ELEM_W-1:0] e);
        logic [ELEM_W-1:0] d;
        d = e - ELEM_W'(1);
        return d[LBL_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/disjoint_set_join_move_query.sv
// Query: the label of the first element is read, then its statistics; ST_QOUT offers the result.
// Move: both labels and statistics are read, then both sets are updated; same-set or ignored
// words end before any write. Join: a one-entry-per-cycle sweep of the label RAM relabels the folded set.
// One word is in work at a time; a finished result waits in the output register.
// After reset a clearing pass writes all MAX_ELEMENTS entries of both RAMs (in_ready low);
// element_count resets to 1024 and can be written at any time.
`default_nettype none

module disjoint_set_join_move_query (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  opcode,
    input  wire logic [dsj_pkg::ELEM_W-1:0]  first_element,
    input  wire logic [dsj_pkg::ELEM_W-1:0]  second_element,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [dsj_pkg::CNT_W-1:0]        set_size,
    output logic [dsj_pkg::SUM_W-1:0]        set_sum,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [dsj_pkg::ELEM_W-1:0]  element_count
);

    logic [dsj_pkg::ELEM_W-1:0] count_reg;
    logic                       out_valid_reg;
    logic [dsj_pkg::CNT_W-1:0]  size_reg;
    logic [dsj_pkg::SUM_W-1:0]  sum_reg;

    dsj_pkg::lbl_req_t          lbl_req;
    dsj_pkg::st_req_t           st_req;
    dsj_pkg::res_t              res;
    logic [dsj_pkg::LBL_W-1:0]  lbl_rdata;
    dsj_pkg::stat_t             st_rdata;
    logic                       res_take;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= dsj_pkg::ELEM_W'(1024);
        end
        else if (cfg_valid)
        begin
            count_reg <= element_count;
        end
    end

    // label of each element
    dsj_ram #(
        .WIDTH (dsj_pkg::LBL_W),
        .DEPTH (dsj_pkg::MAX_ELEMENTS)
    ) u_lbl_ram (
        .clk   (clk),
        .we    (lbl_req.we),
        .waddr (lbl_req.waddr),
        .wdata (lbl_req.wdata),
        .re    (lbl_req.re),
        .raddr (lbl_req.raddr),
        .rdata (lbl_rdata)
    );

    // member count and sum of each label
    dsj_ram #(
        .WIDTH ($bits(dsj_pkg::stat_t)),
        .DEPTH (dsj_pkg::MAX_ELEMENTS)
    ) u_stat_ram (
        .clk   (clk),
        .we    (st_req.we),
        .waddr (st_req.waddr),
        .wdata (st_req.wdata),
        .re    (st_req.re),
        .raddr (st_req.raddr),
        .rdata (st_rdata)
    );

    dsj_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .first_element  (first_element),
        .second_element (second_element),
        .elem_count     (count_reg),
        .lbl_req        (lbl_req),
        .lbl_rdata      (lbl_rdata),
        .st_req         (st_req),
        .st_rdata       (st_rdata),
        .res            (res),
        .res_take       (res_take)
    );

    // output register
    assign res_take = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid && res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_take)
        begin
            size_reg <= res.size;
            sum_reg  <= res.sum;
        end
    end

    assign out_valid = out_valid_reg;
    assign set_size  = size_reg;
    assign set_sum   = sum_reg;

endmodule

`default_nettype wire

>>> rtl/dsj_ram.sv
`default_nettype none

module dsj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/dsj_seq.sv
`default_nettype none

module dsj_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  opcode,
    input  wire logic [dsj_pkg::ELEM_W-1:0]  first_element,
    input  wire logic [dsj_pkg::ELEM_W-1:0]  second_element,
    input  wire logic [dsj_pkg::ELEM_W-1:0]  elem_count,
    output dsj_pkg::lbl_req_t                lbl_req,
    input  wire logic [dsj_pkg::LBL_W-1:0]   lbl_rdata,
    output dsj_pkg::st_req_t                 st_req,
    input  wire dsj_pkg::stat_t              st_rdata,
    output dsj_pkg::res_t                    res,
    input  wire logic                        res_take
);

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_LA    = 10'b0000000100,
        ST_LB    = 10'b0000001000,
        ST_SA    = 10'b0000010000,
        ST_SB    = 10'b0000100000,
        ST_MV2   = 10'b0001000000,
        ST_ZERO  = 10'b0010000000,
        ST_SWEEP = 10'b0100000000,
        ST_QOUT  = 10'b1000000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [dsj_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic                          pend_reg, pend_next;

    logic [1:0]                    op_reg, op_next;
    logic [dsj_pkg::ELEM_W-1:0]    a_reg, a_next;
    logic [dsj_pkg::ELEM_W-1:0]    b_reg, b_next;
    logic [dsj_pkg::LBL_W-1:0]     la_reg, la_next;
    logic [dsj_pkg::LBL_W-1:0]     lb_reg, lb_next;
    logic [dsj_pkg::LBL_W-1:0]     from_reg, from_next;
    logic [dsj_pkg::LBL_W-1:0]     into_reg, into_next;
    logic [dsj_pkg::LBL_W-1:0]     paddr_reg, paddr_next;
    dsj_pkg::stat_t                sa_reg, sa_next;

    logic                          item_go;
    logic [dsj_pkg::SUM_W-1:0]     a_sum;

    // item needs work at all
    always_comb
    begin
        item_go = 1'b0;
        if (opcode inside {dsj_pkg::OP_JOIN, dsj_pkg::OP_MOVE})
        begin
            item_go = dsj_pkg::elem_ok(first_element, elem_count)
                   && dsj_pkg::elem_ok(second_element, elem_count);
        end
        else if (opcode == dsj_pkg::OP_QUERY)
        begin
            item_go = dsj_pkg::elem_ok(first_element, elem_count);
        end
    end

    assign a_sum = dsj_pkg::SUM_W'(a_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        la_next    = la_reg;
        lb_next    = lb_reg;
        from_next  = from_reg;
        into_next  = into_reg;
        paddr_next = paddr_reg;
        sa_next    = sa_reg;
        in_ready   = 1'b0;
        lbl_req    = '0;
        st_req     = '0;
        res        = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                // label i holds element i+1 alone
                lbl_req.we        = 1'b1;
                lbl_req.waddr     = idx_reg[dsj_pkg::LBL_W-1:0];
                lbl_req.wdata     = idx_reg[dsj_pkg::LBL_W-1:0];
                st_req.we         = 1'b1;
                st_req.waddr      = idx_reg[dsj_pkg::LBL_W-1:0];
                st_req.wdata.cnt  = dsj_pkg::CNT_W'(1);
                st_req.wdata.sum  = dsj_pkg::SUM_W'(idx_reg) + dsj_pkg::SUM_W'(1);
                idx_next          = idx_reg + dsj_pkg::IDX_W'(1);
                if (idx_reg[dsj_pkg::LBL_W-1:0]
                    == dsj_pkg::LBL_W'(dsj_pkg::MAX_ELEMENTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                op_next       = opcode;
                a_next        = first_element;
                b_next        = second_element;
                lbl_req.raddr = dsj_pkg::elem_addr(first_element);
                if (in_valid && item_go)
                begin
                    lbl_req.re = 1'b1;
                    state_next = ST_LA;
                end
            end
            ST_LA:
            begin
                la_next = lbl_rdata;
                if (op_reg == dsj_pkg::OP_QUERY)
                begin
                    st_req.re    = 1'b1;
                    st_req.raddr = lbl_rdata;
                    state_next   = ST_QOUT;
                end
                else
                begin
                    lbl_req.re    = 1'b1;
                    lbl_req.raddr = dsj_pkg::elem_addr(b_reg);
                    state_next    = ST_LB;
                end
            end
            ST_LB:
            begin
                lb_next = lbl_rdata;
                if (lbl_rdata == la_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    st_req.re    = 1'b1;
                    st_req.raddr = la_reg;
                    state_next   = ST_SA;
                end
            end
            ST_SA:
            begin
                sa_next      = st_rdata;
                st_req.re    = 1'b1;
                st_req.raddr = lb_reg;
                state_next   = ST_SB;
            end
            ST_SB:
            begin
                if (op_reg == dsj_pkg::OP_MOVE)
                begin
                    // target set gains the element, relabel it
                    st_req.we        = 1'b1;
                    st_req.waddr     = lb_reg;
                    st_req.wdata.cnt = st_rdata.cnt + dsj_pkg::CNT_W'(1);
                    st_req.wdata.sum = st_rdata.sum + a_sum;
                    lbl_req.we       = 1'b1;
                    lbl_req.waddr    = dsj_pkg::elem_addr(a_reg);
                    lbl_req.wdata    = lb_reg;
                    state_next       = ST_MV2;
                end
                else
                begin
                    // smaller set (first on a tie) is folded into the other
                    if (sa_reg.cnt > st_rdata.cnt)
                    begin
                        from_next = lb_reg;
                        into_next = la_reg;
                    end
                    else
                    begin
                        from_next = la_reg;
                        into_next = lb_reg;
                    end
                    st_req.we        = 1'b1;
                    st_req.waddr     = (sa_reg.cnt > st_rdata.cnt) ? la_reg : lb_reg;
                    st_req.wdata.cnt = sa_reg.cnt + st_rdata.cnt;
                    st_req.wdata.sum = sa_reg.sum + st_rdata.sum;
                    state_next       = ST_ZERO;
                end
            end
            ST_MV2:
            begin
                // source set loses the element
                st_req.we        = 1'b1;
                st_req.waddr     = la_reg;
                st_req.wdata.cnt = sa_reg.cnt - dsj_pkg::CNT_W'(1);
                st_req.wdata.sum = sa_reg.sum - a_sum;
                state_next       = ST_IDLE;
            end
            ST_ZERO:
            begin
                st_req.we    = 1'b1;
                st_req.waddr = from_reg;
                st_req.wdata = '0;
                idx_next     = '0;
                state_next   = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                // read entry idx, relabel the entry read in the previous cycle
                if (idx_reg < dsj_pkg::IDX_W'(dsj_pkg::MAX_ELEMENTS))
                begin
                    lbl_req.re    = 1'b1;
                    lbl_req.raddr = idx_reg[dsj_pkg::LBL_W-1:0];
                    pend_next     = 1'b1;
                    paddr_next    = idx_reg[dsj_pkg::LBL_W-1:0];
                    idx_next      = idx_reg + dsj_pkg::IDX_W'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = ST_IDLE;
                end
                if (pend_reg && (lbl_rdata == from_reg))
                begin
                    lbl_req.we    = 1'b1;
                    lbl_req.waddr = paddr_reg;
                    lbl_req.wdata = into_reg;
                end
            end
            ST_QOUT:
            begin
                res.valid = 1'b1;
                res.size  = st_rdata.cnt;
                res.sum   = st_rdata.sum;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
        end
    end

    // item operands
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        la_reg    <= la_next;
        lb_reg    <= lb_next;
        from_reg  <= from_next;
        into_reg  <= into_next;
        paddr_reg <= paddr_next;
        sa_reg    <= sa_next;
    end

`ifndef ASSERT_OFF
    // a sweep write goes back to the entry read the cycle before
    a_sweep_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP && lbl_req.we)
        |-> ($past(lbl_req.re) && $past(lbl_req.raddr) == lbl_req.waddr))
        else $error("sweep write without matching read");

    // a join only ever merges two distinct labels
    a_join_labels: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ZERO) |-> (from_reg != into_reg))
        else $error("join folds a label into itself");

    // never read and write one stats entry in the same cycle
    a_stat_rw: assert property (@(posedge clk) disable iff (!rst_n)
        !(st_req.we && st_req.re && st_req.waddr == st_req.raddr))
        else $error("stats read and write collide");

    // a result is offered only after a stats read
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(st_req.re))
        else $error("result without stats read");
`endif

endmodule

`default_nettype wire

>>> tb/disjoint_set_join_move_query_test.sv
`timescale 1ns / 1ps

module disjoint_set_join_move_query_test;

    localparam int SETTLE_CYCLES = dsj_pkg::MAX_ELEMENTS + 16;
    localparam int HOLD_CYCLES   = 300;

    // one expected query answer
    typedef struct {
        logic [dsj_pkg::CNT_W-1:0] size;
        logic [dsj_pkg::SUM_W-1:0] sum;
    } set_stats_t;

    // Tracks the partition and queues the answer of every accepted query on an element in use
    class set_stats_board;
        logic [dsj_pkg::LBL_W-1:0]  label_of[dsj_pkg::MAX_ELEMENTS];
        int unsigned                members[dsj_pkg::MAX_ELEMENTS];
        int unsigned                total[dsj_pkg::MAX_ELEMENTS];
        logic [dsj_pkg::ELEM_W-1:0] count_limit;
        set_stats_t                 expected_stats[$];
        int errors, words, joins, moves, same_set, ignored, checked, settings;

        function new();
            foreach (label_of[i])
            begin
                label_of[i] = dsj_pkg::LBL_W'(i);
                members[i]  = 1;
                total[i]    = i + 1;
            end
            count_limit = dsj_pkg::ELEM_W'(dsj_pkg::MAX_ELEMENTS);
        endfunction

        function void set_count(logic [dsj_pkg::ELEM_W-1:0] v);
            count_limit = v;
            settings++;
        endfunction

        function bit in_use(logic [dsj_pkg::ELEM_W-1:0] e);
            return (e != 0) && (e <= count_limit) && (e <= dsj_pkg::MAX_ELEMENTS);
        endfunction

        function int pending();
            return expected_stats.size();
        endfunction

        // apply one accepted word to the partition
        function void note_word(logic [1:0] op, logic [dsj_pkg::ELEM_W-1:0] a,
                                logic [dsj_pkg::ELEM_W-1:0] b);
            logic [dsj_pkg::LBL_W-1:0] la, lb, src_label, dst_label;
            set_stats_t s;
            words++;
            case (op)
                dsj_pkg::OP_JOIN, dsj_pkg::OP_MOVE:
                begin
                    if (!in_use(a) || !in_use(b))
                    begin
                        ignored++;
                        return;
                    end
                    la = label_of[a - 1'b1];
                    lb = label_of[b - 1'b1];
                    if (la == lb)
                    begin
                        same_set++;
                        return;
                    end
                    if (op == dsj_pkg::OP_JOIN)
                    begin
                        // smaller set is relabeled; on a tie the first one
                        joins++;
                        if (members[la] > members[lb])
                        begin
                            src_label = lb;
                            dst_label = la;
                        end
                        else
                        begin
                            src_label = la;
                            dst_label = lb;
                        end
                        foreach (label_of[i])
                            if (label_of[i] == src_label)
                                label_of[i] = dst_label;
                        members[dst_label] += members[src_label];
                        total[dst_label]   += total[src_label];
                        members[src_label] = 0;
                        total[src_label]   = 0;
                    end
                    else
                    begin
                        moves++;
                        members[la] -= 1;
                        total[la]   -= a;
                        members[lb] += 1;
                        total[lb]   += a;
                        label_of[a - 1'b1] = lb;
                    end
                end
                dsj_pkg::OP_QUERY:
                begin
                    if (!in_use(a))
                        ignored++;
                    else
                    begin
                        la = label_of[a - 1'b1];
                        s.size = dsj_pkg::CNT_W'(members[la]);
                        s.sum  = dsj_pkg::SUM_W'(total[la]);
                        expected_stats.push_back(s);
                    end
                end
                default: ignored++;
            endcase
        endfunction

        // compare one accepted result with the oldest query answer
        function void check_result(logic [dsj_pkg::CNT_W-1:0] size,
                                   logic [dsj_pkg::SUM_W-1:0] sum);
            set_stats_t want;
            if (expected_stats.size() == 0)
            begin
                $error("unexpected result: set_size %0d set_sum %0d", size, sum);
                errors++;
                return;
            end
            want = expected_stats.pop_front();
            checked++;
            if (size !== want.size)
            begin
                $error("set_size: expected %0d, got %0d", want.size, size);
                errors++;
            end
            if (sum !== want.sum)
            begin
                $error("set_sum: expected %0d, got %0d", want.sum, sum);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [1:0]                 opcode;
    logic [dsj_pkg::ELEM_W-1:0] first_element;
    logic [dsj_pkg::ELEM_W-1:0] second_element;
    logic                       out_valid;
    logic                       out_ready;
    logic [dsj_pkg::CNT_W-1:0]  set_size;
    logic [dsj_pkg::SUM_W-1:0]  set_sum;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [dsj_pkg::ELEM_W-1:0] element_count;

    logic calm;
    logic squeeze;
    int   input_stalls;

    set_stats_board board = new();

    disjoint_set_join_move_query u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .first_element  (first_element),
        .second_element (second_element),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .set_size       (set_size),
        .set_sum        (set_sum),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .element_count  (element_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #40_000_000;
        $display("** disjoint_set_join_move_query: FAILED **");
        $finish;
    end

    // mostly zero, some short, a few long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // mostly elements in use, the rest zero, out of range or drawn from the whole field
    function automatic logic [dsj_pkg::ELEM_W-1:0] pick_element();
        int r;
        int lim;
        r = $urandom_range(0, 99);
        lim = board.count_limit;
        if (lim == 0)
            lim = 16;
        if (lim > dsj_pkg::MAX_ELEMENTS)
            lim = dsj_pkg::MAX_ELEMENTS;
        if (r < 88)
            return dsj_pkg::ELEM_W'($urandom_range(1, lim));
        else if (r < 92)
            return '0;
        else if (r < 96)
            return dsj_pkg::ELEM_W'($urandom_range(lim + 1, 2047));
        return dsj_pkg::ELEM_W'($urandom_range(0, 2047));
    endfunction

    // monitor: both handshakes sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(set_size, set_sum);
            if (in_valid && in_ready)
                board.note_word(opcode, first_element, second_element);
            if (in_valid && !in_ready)
                input_stalls++;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (squeeze)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                squeeze = 1'b0;
            end
            else
            begin
                stall = pick_gap();
                out_ready <= (stall == 0);
                if (stall > 1)
                    repeat (stall - 1) @(negedge clk);
            end
        end
    end

    // one input word; called and returns at a falling edge
    task automatic send_word(input logic [1:0] op, input logic [dsj_pkg::ELEM_W-1:0] a,
                             input logic [dsj_pkg::ELEM_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        opcode         <= op;
        first_element  <= a;
        second_element <= b;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_random();
        int r;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        if (r < 40)
            op = dsj_pkg::OP_QUERY;
        else if (r < 60)
            op = dsj_pkg::OP_JOIN;
        else if (r < 90)
            op = dsj_pkg::OP_MOVE;
        else
            op = dsj_pkg::OP_NOP;
        send_word(op, pick_element(), pick_element());
    endtask

    task automatic write_count(input logic [dsj_pkg::ELEM_W-1:0] v);
        @(negedge clk);
        cfg_valid     <= 1'b1;
        element_count <= v;
        do @(posedge clk); while (!cfg_ready);
        board.set_count(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // all answers in, then room for a full join sweep to finish
    task automatic settle();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [dsj_pkg::ELEM_W-1:0] cnt, input int n,
                             input logic quiet);
        settle();
        write_count(cnt);
        calm = quiet;
        repeat (n) send_random();
        in_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = dsj_pkg::OP_NOP;
        first_element  = '0;
        second_element = '0;
        cfg_valid      = 1'b0;
        element_count  = dsj_pkg::ELEM_W'(dsj_pkg::MAX_ELEMENTS);
        calm           = 1'b0;
        squeeze        = 1'b0;
        input_stalls   = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, ties, same-set, ignored words
        write_count(dsj_pkg::ELEM_W'(dsj_pkg::MAX_ELEMENTS));
        send_word(dsj_pkg::OP_QUERY, 11'd1, 11'd0);
        send_word(dsj_pkg::OP_QUERY, 11'd1024, 11'd2047);
        send_word(dsj_pkg::OP_QUERY, 11'd0, 11'd1);
        send_word(dsj_pkg::OP_QUERY, 11'd2047, 11'd1);
        send_word(dsj_pkg::OP_QUERY, 11'd1025, 11'd1);
        send_word(dsj_pkg::OP_JOIN, 11'd1, 11'd2);
        send_word(dsj_pkg::OP_QUERY, 11'd1, 11'd0);
        send_word(dsj_pkg::OP_JOIN, 11'd2, 11'd1);
        send_word(dsj_pkg::OP_JOIN, 11'd1024, 11'd3);
        send_word(dsj_pkg::OP_QUERY, 11'd1024, 11'd0);
        send_word(dsj_pkg::OP_JOIN, 11'd3, 11'd1);
        send_word(dsj_pkg::OP_QUERY, 11'd2, 11'd0);
        send_word(dsj_pkg::OP_MOVE, 11'd1, 11'd5);
        send_word(dsj_pkg::OP_MOVE, 11'd2, 11'd3);
        send_word(dsj_pkg::OP_QUERY, 11'd5, 11'd0);
        send_word(dsj_pkg::OP_MOVE, 11'd0, 11'd5);
        send_word(dsj_pkg::OP_JOIN, 11'd5, 11'd0);
        send_word(dsj_pkg::OP_JOIN, 11'd5, 11'd2047);
        send_word(dsj_pkg::OP_NOP, 11'd1, 11'd2);
        send_word(dsj_pkg::OP_NOP, 11'd2047, 11'd2047);
        send_word(dsj_pkg::OP_QUERY, 11'd2, 11'd0);
        send_word(dsj_pkg::OP_MOVE, 11'd7, 11'd5);
        send_word(dsj_pkg::OP_QUERY, 11'd5, 11'd2047);
        in_valid <= 1'b0;

        // random phases over several element counts
        run_phase(11'd16, 90, 1'b0);
        run_phase(11'd1, 30, 1'b0);
        run_phase(11'd0, 20, 1'b0);
        run_phase(11'd2047, 150, 1'b0);
        run_phase(11'd200, 130, 1'b1);
        run_phase(dsj_pkg::ELEM_W'(dsj_pkg::MAX_ELEMENTS), 60, 1'b0);

        // back-to-back queries against a long output hold-off
        squeeze = 1'b1;
        calm    = 1'b1;
        repeat (40)
            send_word(dsj_pkg::OP_QUERY,
                      dsj_pkg::ELEM_W'($urandom_range(1, dsj_pkg::MAX_ELEMENTS)), '0);
        calm = 1'b0;
        repeat (40) send_random();
        in_valid <= 1'b0;
        settle();
        board.errors += board.pending();

        $display("Covered %0d words over %0d element counts: %0d answers checked, %0d joins,",
                 board.words, board.settings, board.checked, board.joins);
        $display("%0d moves, %0d same-set, %0d ignored; input held off %0d cycles.",
                 board.moves, board.same_set, board.ignored, input_stalls);
        if (board.errors == 0)
            $display("** disjoint_set_join_move_query: PASSED **");
        else
            $display("** disjoint_set_join_move_query: FAILED **");
        $finish;
    end

endmodule
